[hdl/particle_pair_collision_macros.svh]
// ----------------------------------------------------------------------------
// Particle pair collision: assertion macros
// Shorthand for clocked checks on the top level's ports.
// ----------------------------------------------------------------------------
`ifndef PARTICLE_PAIR_COLLISION_MACROS_SVH
`define PARTICLE_PAIR_COLLISION_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define PPC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("particle_pair_collision: port check failed");

// The consequent holds in the cycle after the antecedent.
`define PPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("particle_pair_collision: port check failed");

// The consequent holds after the given delay, counted from the antecedent.
`define PPC_ASSERT_LATER(lbl, ante, dly, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
    else $error("particle_pair_collision: port check failed");

`endif

[hdl/ppc_pkg.sv]
// ----------------------------------------------------------------------------
// Particle pair collision package
// Widths, register codes, sequencer states and Q16.16 helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package ppc_pkg;

  localparam int MAX_PARTICLES_DEF = 64;
  localparam int Q_W       = 32;
  localparam int CFG_W     = 31;
  localparam int PIDX_W    = 6;
  localparam int CIDX_W    = 3;
  localparam int MUL_W     = 33;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int DIV_NUM_W = 51;
  localparam int DIV_DEN_W = 34;

  localparam logic [CIDX_W-1:0] CFG_BOX_X   = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_BOX_Y   = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_BOX_Z   = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_TSTEP   = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_SPACING = 3'd4;

  localparam logic [CFG_W-1:0] BOX_RST     = 31'd65536;
  localparam logic [CFG_W-1:0] TSTEP_RST   = 31'd66;
  localparam logic [CFG_W-1:0] SPACING_RST = 31'd6554;

  localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

  typedef enum logic [3:0] {
    S_LOAD,
    S_FETCH,
    S_DISP,
    S_DIST,
    S_DOT,
    S_DEN,
    S_FDIV,
    S_RJ,
    S_RI,
    S_SCALE,
    S_UPD,
    S_NEXT,
    S_EMIT
  } state_t;

  function automatic logic signed [Q_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    hi = PROD_W'(Q_MAX);
    lo = PROD_W'(Q_MIN);
    if (v > hi) begin
      return Q_MAX;
    end else if (v < lo) begin
      return Q_MIN;
    end
    return v[Q_W-1:0];
  endfunction

  // Product rounded down to Q16.16 and saturated.
  function automatic logic signed [Q_W-1:0] qround(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-17:0] fl;
    fl = $signed(p[PROD_W-1:16]);
    return sat32(PROD_W'(fl));
  endfunction

  // Displacement folded back into the periodic box.
  function automatic logic signed [Q_W-1:0] wrap_disp(input logic signed [Q_W-1:0] pj,
                                                      input logic signed [Q_W-1:0] pi,
                                                      input logic [CFG_W-1:0] len);
    logic signed [34:0] d;
    logic signed [34:0] d2;
    logic signed [34:0] l;
    d  = 35'(pj) - 35'(pi);
    d2 = d <<< 1;
    l  = $signed({4'b0, len});
    if (d2 < -l) begin
      d = d + l;
    end else if (d2 > l) begin
      d = d - l;
    end
    return sat32(PROD_W'(d));
  endfunction

endpackage

`default_nettype wire

[hdl/ppc_mul.sv]
// ----------------------------------------------------------------------------
// Particle pair collision: shared multiplier
// Signed 33 by 33 bit multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module ppc_mul (
  input  logic                                 clk,
  input  logic signed [ppc_pkg::MUL_W-1:0]     a,
  input  logic signed [ppc_pkg::MUL_W-1:0]     b,
  output logic signed [ppc_pkg::PROD_W-1:0]    p
);
  import ppc_pkg::*;

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

`default_nettype wire

[hdl/ppc_div.sv]
// ----------------------------------------------------------------------------
// Particle pair collision: iterative divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ppc_div #(
  parameter int NUM_W = ppc_pkg::DIV_NUM_W,
  parameter int DEN_W = ppc_pkg::DIV_DEN_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);
  import ppc_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dvsr;
  logic [CNT_W-1:0] cnt;
  logic             active;
  logic [DEN_W:0]   trial;
  logic             ge;
  logic [DEN_W-1:0] rem_next;

  always_comb begin
    trial    = {rem, quo[NUM_W-1]};
    ge       = trial >= {1'b0, dvsr};
    rem_next = ge ? DEN_W'(trial - {1'b0, dvsr}) : DEN_W'(trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= CNT_W'(NUM_W);
      end else if (active) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quo  <= num;
      dvsr <= den;
    end else if (active) begin
      rem <= rem_next;
      quo <= {quo[NUM_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

[hdl/particle_pair_collision.sv]
// ----------------------------------------------------------------------------
// Particle pair collision
// Loads particles, runs a collision correction over all ordered pairs and
// reports the corrected velocities in index order.
//
//   channel   handshake              payload
//   input     start, busy            pos_*, vel_in_*, density, last_particle
//   result    done (one-cycle strobe) particle_index, vel_out_*, last_result
//   config    cfg_valid, cfg_ready   cfg_index, cfg_data
//
// A particle request is taken whenever busy is low; one with last_particle
// set starts the pass, where each pair in contact runs three divisions on
// the shared divider. Results follow in index order, paced by the registered
// memory read. Reset is synchronous and empties the particle store; the
// result receiver cannot stall, and cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module particle_pair_collision #(
  parameter int MAX_PARTICLES = ppc_pkg::MAX_PARTICLES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [ppc_pkg::Q_W-1:0]     pos_x,
  input  logic signed [ppc_pkg::Q_W-1:0]     pos_y,
  input  logic signed [ppc_pkg::Q_W-1:0]     pos_z,
  input  logic signed [ppc_pkg::Q_W-1:0]     vel_in_x,
  input  logic signed [ppc_pkg::Q_W-1:0]     vel_in_y,
  input  logic signed [ppc_pkg::Q_W-1:0]     vel_in_z,
  input  logic [ppc_pkg::CFG_W-1:0]          density,
  input  logic                               last_particle,
  output logic                               done,
  output logic [ppc_pkg::PIDX_W-1:0]         particle_index,
  output logic signed [ppc_pkg::Q_W-1:0]     vel_out_x,
  output logic signed [ppc_pkg::Q_W-1:0]     vel_out_y,
  output logic signed [ppc_pkg::Q_W-1:0]     vel_out_z,
  output logic                               last_result,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ppc_pkg::CIDX_W-1:0]         cfg_index,
  input  logic [ppc_pkg::CFG_W-1:0]          cfg_data
);
  import ppc_pkg::*;

  localparam int IDX_W = $clog2(MAX_PARTICLES);
  localparam int CNT_W = $clog2(MAX_PARTICLES + 1);

  // Configuration registers.
  logic [CFG_W-1:0] box_x, box_y, box_z, tstep, spacing;
  logic [CFG_W-1:0] box_len [3];

  // Sequencer.
  state_t           state, state_next;
  logic [2:0]       k, k_next;
  logic             half, half_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] npart, npart_next;
  logic [CNT_W-1:0] pi, pi_next;
  logic [CNT_W-1:0] pj, pj_next;
  logic             pair_done;
  logic [CNT_W:0]   jn;
  logic             accept, load_we, collide, emit_fire, emit_last;

  // Memory ports.
  logic [IDX_W-1:0]        load_addr, addr_i, addr_j, vel_waddr;
  logic signed [Q_W-1:0]   pos_in [3];
  logic signed [Q_W-1:0]   vel_in [3];
  logic                    vel_we [3];
  logic signed [Q_W-1:0]   vel_wdata [3];
  logic signed [Q_W-1:0]   rd_pi [3];
  logic signed [Q_W-1:0]   rd_pj [3];
  logic signed [Q_W-1:0]   rd_vi [3];
  logic signed [Q_W-1:0]   rd_vj [3];
  logic [CFG_W-1:0]        rd_mi, rd_mj;
  logic [CFG_W-1:0]        dens_mem [MAX_PARTICLES];

  // Pair working registers.
  logic signed [Q_W-1:0]   d [3];
  logic signed [Q_W-1:0]   dv [3];
  logic [Q_W-1:0]          msum;
  logic [63:0]             dist2;
  logic signed [49:0]      dot_acc;
  logic signed [Q_W-1:0]   dot, f, ai, aj;
  logic [CFG_W-1:0]        den;
  logic [Q_W-1:0]          ri, rj;

  // Shared units.
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic                     div_start, div_done;
  logic [DIV_NUM_W-1:0]     div_num, div_q;
  logic [DIV_DEN_W-1:0]     div_den;

  logic [1:0]               k2, axis;
  logic [Q_W-1:0]           dot_mag;
  logic [34:0]              dot_mag6;
  logic signed [Q_W-1:0]    fq, term, upd_val;

  ppc_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  ppc_div #(
    .NUM_W (DIV_NUM_W),
    .DEN_W (DIV_DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_q)
  );

  assign cfg_ready = 1'b1;
  assign box_len[0] = box_x;
  assign box_len[1] = box_y;
  assign box_len[2] = box_z;
  assign pos_in[0] = pos_x;
  assign pos_in[1] = pos_y;
  assign pos_in[2] = pos_z;
  assign vel_in[0] = vel_in_x;
  assign vel_in[1] = vel_in_y;
  assign vel_in[2] = vel_in_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_x   <= BOX_RST;
      box_y   <= BOX_RST;
      box_z   <= BOX_RST;
      tstep   <= TSTEP_RST;
      spacing <= SPACING_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BOX_X:   box_x   <= cfg_data;
        CFG_BOX_Y:   box_y   <= cfg_data;
        CFG_BOX_Z:   box_z   <= cfg_data;
        CFG_TSTEP:   tstep   <= cfg_data;
        CFG_SPACING: spacing <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- memories
  assign accept    = start && !busy;
  assign load_we   = accept && (count < CNT_W'(MAX_PARTICLES));
  assign load_addr = count[IDX_W-1:0];
  assign addr_i    = pi[IDX_W-1:0];
  assign addr_j    = pj[IDX_W-1:0];
  assign k2        = k[1:0];
  assign axis      = k[2:1];

  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic signed [Q_W-1:0] pos_mem [MAX_PARTICLES];
    logic signed [Q_W-1:0] vel_mem [MAX_PARTICLES];

    always_ff @(posedge clk) begin
      if (load_we) begin
        pos_mem[load_addr] <= pos_in[a];
      end
      rd_pi[a] <= pos_mem[addr_i];
      rd_pj[a] <= pos_mem[addr_j];
    end

    always_ff @(posedge clk) begin
      if (vel_we[a]) begin
        vel_mem[vel_waddr] <= vel_wdata[a];
      end
      rd_vi[a] <= vel_mem[addr_i];
      rd_vj[a] <= vel_mem[addr_j];
    end
  end

  always_ff @(posedge clk) begin
    if (load_we) begin
      dens_mem[load_addr] <= density;
    end
    rd_mi <= dens_mem[addr_i];
    rd_mj <= dens_mem[addr_j];
  end

  // Velocity write port: loading, or one axis of one particle per update step.
  always_comb begin
    term      = qround(mul_p);
    upd_val   = k[0] ? sat32(PROD_W'(rd_vj[axis]) + PROD_W'(term))
                     : sat32(PROD_W'(rd_vi[axis]) - PROD_W'(term));
    vel_waddr = load_we ? load_addr : (k[0] ? addr_j : addr_i);
    for (int a = 0; a < 3; a++) begin
      vel_we[a]    = load_we ||
                     (state == S_UPD && half && axis == 2'(a));
      vel_wdata[a] = load_we ? vel_in[a] : upd_val;
    end
  end

  // --------------------------------------------------------------- sequencer
  assign collide   = {dist2, 2'b00} < {4'b0, mul_p[61:0]};
  assign emit_fire = (state == S_EMIT) && half;
  assign emit_last = pi == (npart - CNT_W'(1));

  always_comb begin
    pair_done = 1'b0;
    pi_next   = pi;
    pj_next   = pj;
    jn        = {1'b0, pj} + 1'b1;
    if (jn == {1'b0, pi}) begin
      jn = jn + 1'b1;
    end
    if (state == S_LOAD) begin
      if (accept && last_particle) begin
        pi_next = '0;
        pj_next = CNT_W'(1);
      end
    end else if (state == S_NEXT) begin
      if (jn < {1'b0, npart}) begin
        pj_next = jn[CNT_W-1:0];
      end else if (({1'b0, pi} + 1'b1) < {1'b0, npart}) begin
        pi_next = pi + 1'b1;
        pj_next = '0;
      end else begin
        pair_done = 1'b1;
        pi_next   = '0;
      end
    end else if (emit_fire) begin
      pi_next = pi + 1'b1;
    end
  end

  always_comb begin
    count_next = load_we ? count + 1'b1 : count;
    npart_next = npart;
    if (accept && last_particle) begin
      npart_next = count_next;
      count_next = '0;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD: begin
        if (accept && last_particle) begin
          state_next = (npart_next >= CNT_W'(2)) ? S_FETCH : S_EMIT;
        end
      end
      S_FETCH: state_next = S_DISP;
      S_DISP: begin
        if (k == 3'd2) state_next = S_DIST;
      end
      S_DIST: begin
        if (half && k == 3'd3) state_next = collide ? S_DOT : S_NEXT;
      end
      S_DOT: begin
        if (half && k == 3'd2) state_next = S_DEN;
      end
      S_DEN: begin
        if (half) state_next = S_FDIV;
      end
      S_FDIV: begin
        if ((!half && den == '0) || (half && div_done)) state_next = S_RJ;
      end
      S_RJ: begin
        if ((!half && msum == '0) || (half && div_done)) state_next = S_RI;
      end
      S_RI: begin
        if ((!half && msum == '0) || (half && div_done)) state_next = S_SCALE;
      end
      S_SCALE: begin
        if (half && k == 3'd1) state_next = S_UPD;
      end
      S_UPD: begin
        if (half && k == 3'd5) state_next = S_NEXT;
      end
      S_NEXT: state_next = pair_done ? S_EMIT : S_FETCH;
      S_EMIT: begin
        if (emit_fire && emit_last) state_next = S_LOAD;
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_comb begin
    k_next    = k;
    half_next = half;
    if (state_next != state) begin
      k_next    = '0;
      half_next = 1'b0;
    end else begin
      case (state)
        S_DISP: k_next = k + 1'b1;
        S_DIST, S_DOT, S_DEN, S_SCALE, S_UPD: begin
          half_next = !half;
          if (half) k_next = k + 1'b1;
        end
        S_EMIT: half_next = !half;
        S_FDIV, S_RJ, S_RI: half_next = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      k     <= '0;
      half  <= 1'b0;
      count <= '0;
      npart <= '0;
      pi    <= '0;
      pj    <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      k     <= k_next;
      half  <= half_next;
      count <= count_next;
      npart <= npart_next;
      pi    <= pi_next;
      pj    <= pj_next;
      done  <= emit_fire;
    end
  end

  // ----------------------------------------------------- unit operand select
  always_comb begin
    busy     = state != S_LOAD;
    dot_mag  = dot[Q_W-1] ? 32'(-33'(dot)) : 32'(dot);
    dot_mag6 = 35'({dot_mag, 2'b00}) + 35'({dot_mag, 1'b0});
    mul_a    = '0;
    mul_b    = '0;
    div_num  = '0;
    div_den  = '0;
    div_start = 1'b0;
    unique case (state)
      S_DIST: begin
        if (k == 3'd3) begin
          mul_a = {2'b00, spacing};
          mul_b = {2'b00, spacing};
        end else begin
          mul_a = MUL_W'(d[k2]);
          mul_b = MUL_W'(d[k2]);
        end
      end
      S_DOT: begin
        mul_a = MUL_W'(d[k2]);
        mul_b = MUL_W'(dv[k2]);
      end
      S_DEN: begin
        mul_a = {2'b00, tstep};
        mul_b = {1'b0, msum};
      end
      S_FDIV: begin
        div_num   = {dot_mag6, 16'b0};
        div_den   = DIV_DEN_W'({den, 2'b00}) + DIV_DEN_W'(den);
        div_start = !half && den != '0;
      end
      S_RJ: begin
        div_num   = DIV_NUM_W'({rd_mj, 16'b0});
        div_den   = DIV_DEN_W'(msum);
        div_start = !half && msum != '0;
      end
      S_RI: begin
        div_num   = DIV_NUM_W'({rd_mi, 16'b0});
        div_den   = DIV_DEN_W'(msum);
        div_start = !half && msum != '0;
      end
      S_SCALE: begin
        mul_a = MUL_W'(f);
        mul_b = {1'b0, k[0] ? ri : rj};
      end
      S_UPD: begin
        mul_a = MUL_W'(k[0] ? ai : aj);
        mul_b = MUL_W'(d[axis]);
      end
      default: ;
    endcase
  end

  // ------------------------------------------------------------------ datapath
  always_comb begin
    if (dot[Q_W-1]) begin
      fq = sat32(-$signed(PROD_W'(div_q)));
    end else begin
      fq = sat32($signed(PROD_W'(div_q)));
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_DISP: begin
        d[k2]   <= wrap_disp(rd_pj[k2], rd_pi[k2], box_len[k2]);
        dv[k2]  <= sat32(PROD_W'(rd_vi[k2]) - PROD_W'(rd_vj[k2]));
        msum    <= {1'b0, rd_mi} + {1'b0, rd_mj};
        dist2   <= '0;
        dot_acc <= '0;
      end
      S_DIST: begin
        if (half && k != 3'd3) dist2 <= dist2 + mul_p[63:0];
      end
      S_DOT: begin
        if (half) dot_acc <= dot_acc + $signed(mul_p[PROD_W-1:16]);
      end
      S_DEN: begin
        if (half) begin
          den <= (|mul_p[62:47]) ? '1 : mul_p[46:16];
          dot <= sat32(PROD_W'(dot_acc));
        end
      end
      S_FDIV: begin
        // With no denominator the impulse runs to the limit set by the sign, or to zero.
        if (!half && den == '0) begin
          if (dot > 0) begin
            f <= Q_MAX;
          end else if (dot < 0) begin
            f <= Q_MIN;
          end else begin
            f <= '0;
          end
        end else if (half && div_done) begin
          f <= fq;
        end
      end
      S_RJ: begin
        if (!half && msum == '0) begin
          rj <= '0;
        end else if (half && div_done) begin
          rj <= div_q[Q_W-1:0];
        end
      end
      S_RI: begin
        if (!half && msum == '0) begin
          ri <= '0;
        end else if (half && div_done) begin
          ri <= div_q[Q_W-1:0];
        end
      end
      S_SCALE: begin
        if (half) begin
          if (k[0]) begin
            ai <= qround(mul_p);
          end else begin
            aj <= qround(mul_p);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      particle_index <= PIDX_W'(pi);
      vel_out_x      <= rd_vi[0];
      vel_out_y      <= rd_vi[1];
      vel_out_z      <= rd_vi[2];
      last_result    <= emit_last;
    end
  end

endmodule

`default_nettype wire

[hdl/ppc_checker.sv]
// ----------------------------------------------------------------------------
// Particle pair collision: port checker
// Timing checks on the result strobe and the busy flag, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "particle_pair_collision_macros.svh"

module ppc_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic                       last_particle,
  input logic                       done,
  input logic                       last_result,
  input logic [ppc_pkg::PIDX_W-1:0] particle_index
);
  import ppc_pkg::*;

  // Results of one pass never come back to back and count up by one.
  `PPC_ASSERT_NEXT(a_result_gap, done && !last_result, !done)
  `PPC_ASSERT_LATER(a_index_step, done && !last_result, 2, done && particle_index == PIDX_W'($past(particle_index, 2) + 1'b1))
  // The block stays busy until the final result of a pass is out.
  `PPC_ASSERT_NOW(a_mid_busy, done && !last_result, busy)
  `PPC_ASSERT_NOW(a_last_idle, done && last_result, !busy)
  // A request marked last always starts a pass.
  `PPC_ASSERT_NEXT(a_pass_starts, start && !busy && last_particle, busy)

endmodule

bind particle_pair_collision ppc_checker u_ppc_checker (.*);

`default_nettype wire

[sim/particle_pair_collision_checker.sv]
// ----------------------------------------------------------------------------
// Particle pair collision checker
// Watches the particle, configuration and velocity report channels, keeps its
// own copy of the particle store and registers, predicts every corrected
// velocity when a pass starts and compares each report with the oldest one.
// ----------------------------------------------------------------------------
`default_nettype none

module particle_pair_collision_checker
  import ppc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      busy,
  input  logic signed [Q_W-1:0]     pos_x,
  input  logic signed [Q_W-1:0]     pos_y,
  input  logic signed [Q_W-1:0]     pos_z,
  input  logic signed [Q_W-1:0]     vel_in_x,
  input  logic signed [Q_W-1:0]     vel_in_y,
  input  logic signed [Q_W-1:0]     vel_in_z,
  input  logic [CFG_W-1:0]          density,
  input  logic                      last_particle,
  input  logic                      done,
  input  logic [PIDX_W-1:0]         particle_index,
  input  logic signed [Q_W-1:0]     vel_out_x,
  input  logic signed [Q_W-1:0]     vel_out_y,
  input  logic signed [Q_W-1:0]     vel_out_z,
  input  logic                      last_result,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [CIDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  output int                        errors,
  output int                        pending
);

  localparam longint QMAX_L = 64'sd2147483647;
  localparam longint QMIN_L = -64'sd2147483648;

  typedef struct {
    logic [PIDX_W-1:0]     idx;
    logic signed [Q_W-1:0] vx;
    logic signed [Q_W-1:0] vy;
    logic signed [Q_W-1:0] vz;
    logic                  last;
  } vel_report_t;

  vel_report_t velocity_reports[$];

  longint          pos_mem[3][MAX_PARTICLES_DEF];
  longint          vel_mem[3][MAX_PARTICLES_DEF];
  longint unsigned mass_mem[MAX_PARTICLES_DEF];
  int              n_loaded;
  longint unsigned box_len[3];
  longint unsigned tstep;
  longint unsigned spacing;

  function automatic longint clamp32(input longint v);
    if (v > QMAX_L) return QMAX_L;
    if (v < QMIN_L) return QMIN_L;
    return v;
  endfunction

  // Rounds towards minus infinity when dropping the 16 fraction bits.
  function automatic longint floor_q16(input longint p);
    if (p >= 0) return p >>> 16;
    return -((-p + 65535) >>> 16);
  endfunction

  function automatic longint qprod(input longint a, input longint b);
    return clamp32(floor_q16(a * b));
  endfunction

  function automatic longint fold(input longint d, input longint unsigned len);
    longint l;
    l = longint'(len);
    if (2 * d < -l) d = d + l;
    else if (2 * d > l) d = d - l;
    return clamp32(d);
  endfunction

  task automatic collide(input int a, input int b);
    longint          d[3];
    longint          dot;
    longint          f;
    longint          ri;
    longint          rj;
    longint unsigned dist2;
    longint unsigned s2;
    longint unsigned msum;
    longint unsigned den;
    dist2 = 0;
    for (int k = 0; k < 3; k++) begin
      d[k] = fold(pos_mem[k][b] - pos_mem[k][a], box_len[k]);
      dist2 += longint'(d[k] * d[k]);
    end
    s2 = spacing * spacing;
    if (dist2 >= 64'h4000_0000_0000_0000 || 4 * dist2 >= s2) return;
    dot = 0;
    for (int k = 0; k < 3; k++)
      dot += floor_q16(d[k] * clamp32(vel_mem[k][a] - vel_mem[k][b]));
    dot = clamp32(dot);
    msum = mass_mem[a] + mass_mem[b];
    den = (tstep * msum) >> 16;
    if (den > 64'd2147483647) den = 64'd2147483647;
    if (den == 0) f = (dot > 0) ? QMAX_L : ((dot < 0) ? QMIN_L : 0);
    else f = clamp32((dot * 6 * 65536) / longint'(5 * den));
    if (msum == 0) begin
      ri = 0;
      rj = 0;
    end else begin
      ri = longint'((mass_mem[a] << 16) / msum);
      rj = longint'((mass_mem[b] << 16) / msum);
    end
    for (int k = 0; k < 3; k++) begin
      vel_mem[k][a] = clamp32(vel_mem[k][a] - qprod(qprod(f, rj), d[k]));
      vel_mem[k][b] = clamp32(vel_mem[k][b] + qprod(qprod(f, ri), d[k]));
    end
  endtask

  task automatic run_collision_pass();
    vel_report_t r;
    for (int i = 0; i < n_loaded; i++)
      for (int j = 0; j < n_loaded; j++)
        if (i != j) collide(i, j);
    for (int i = 0; i < n_loaded; i++) begin
      r.idx  = PIDX_W'(i);
      r.vx   = Q_W'(vel_mem[0][i]);
      r.vy   = Q_W'(vel_mem[1][i]);
      r.vz   = Q_W'(vel_mem[2][i]);
      r.last = (i == n_loaded - 1);
      velocity_reports.push_back(r);
    end
    n_loaded = 0;
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("%0t: velocity report mismatch on %s: expected %h, got %h",
             $time, field, want, got);
    errors++;
  endtask

  initial begin
    errors  = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    vel_report_t want;
    if (rst) begin
      box_len[0] = BOX_RST;
      box_len[1] = BOX_RST;
      box_len[2] = BOX_RST;
      tstep      = TSTEP_RST;
      spacing    = SPACING_RST;
      n_loaded   = 0;
    end else begin
      if (done) begin
        if (velocity_reports.size() == 0) begin
          $display("%0t: velocity report for particle %0d with none expected",
                   $time, particle_index);
          errors++;
        end else begin
          want = velocity_reports.pop_front();
          if (particle_index !== want.idx) report_mismatch("index", want.idx, particle_index);
          if (vel_out_x !== want.vx) report_mismatch("vel_out_x", want.vx, vel_out_x);
          if (vel_out_y !== want.vy) report_mismatch("vel_out_y", want.vy, vel_out_y);
          if (vel_out_z !== want.vz) report_mismatch("vel_out_z", want.vz, vel_out_z);
          if (last_result !== want.last) report_mismatch("last_result", want.last, last_result);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BOX_X:   box_len[0] = cfg_data;
          CFG_BOX_Y:   box_len[1] = cfg_data;
          CFG_BOX_Z:   box_len[2] = cfg_data;
          CFG_TSTEP:   tstep      = cfg_data;
          CFG_SPACING: spacing    = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        // Requests beyond a full store are dropped, but their last mark counts.
        if (n_loaded < MAX_PARTICLES_DEF) begin
          pos_mem[0][n_loaded] = pos_x;
          pos_mem[1][n_loaded] = pos_y;
          pos_mem[2][n_loaded] = pos_z;
          vel_mem[0][n_loaded] = vel_in_x;
          vel_mem[1][n_loaded] = vel_in_y;
          vel_mem[2][n_loaded] = vel_in_z;
          mass_mem[n_loaded]   = density;
          n_loaded++;
        end
        if (last_particle) run_collision_pass();
      end
    end
    pending = velocity_reports.size();
  end

endmodule

`default_nettype wire

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// Particle pair collision testbench
// Drives particle sets, some packed into contact and some spread out, under a
// range of box, time step and spacing settings, with bursty request timing.
// The checker beside the block predicts and compares every velocity report.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import ppc_pkg::*;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic signed [Q_W-1:0] pos_x, pos_y, pos_z;
  logic signed [Q_W-1:0] vel_in_x, vel_in_y, vel_in_z;
  logic [CFG_W-1:0]      density;
  logic                  last_particle;
  logic                  done;
  logic [PIDX_W-1:0]     particle_index;
  logic signed [Q_W-1:0] vel_out_x, vel_out_y, vel_out_z;
  logic                  last_result;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CIDX_W-1:0]     cfg_index;
  logic [CFG_W-1:0]      cfg_data;
  int                    errors;
  int                    pending;

  int                    burst_left;
  longint                cur_box;
  longint                cur_spacing;

  particle_pair_collision dut (.*);

  particle_pair_collision_checker checker_i (.*);

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  initial begin
    #(12 * 4000000);
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic signed [Q_W-1:0] any_velocity();
    case ($urandom_range(0, 7))
      0:       return Q_MAX;
      1:       return Q_MIN;
      2, 3:    return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] any_mass();
    case ($urandom_range(0, 5))
      0:       return 1;
      1:       return 31'h7FFF_FFFF;
      2, 3:    return $urandom_range(1, 1 << 18);
      default: return $urandom_range(1, 32'h7FFF_FFFF);
    endcase
  endfunction

  task automatic send_particle(input logic signed [Q_W-1:0] px, py, pz, vx, vy, vz,
                               input logic [CFG_W-1:0] m, input logic lst);
    if (burst_left == 0) begin
      start = 1'b0;
      if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 9)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    start         = 1'b1;
    pos_x         = px;
    pos_y         = py;
    pos_z         = pz;
    vel_in_x      = vx;
    vel_in_y      = vy;
    vel_in_z      = vz;
    density       = m;
    last_particle = lst;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    burst_left--;
  endtask

  // Packed sets cluster within a fraction of the spacing, sometimes one box length
  // apart so contact is only found through the periodic wrap; others are random.
  task automatic send_set(input int n, input bit packed_set);
    logic signed [Q_W-1:0] base[3];
    logic signed [Q_W-1:0] p[3];
    longint                r;
    r = cur_spacing / 6;
    if (r > (1 << 20)) r = 1 << 20;
    if (r < 1) r = 1;
    for (int k = 0; k < 3; k++) base[k] = $urandom;
    for (int i = 0; i < n; i++) begin
      for (int k = 0; k < 3; k++) begin
        if (packed_set) begin
          p[k] = Q_W'(longint'(base[k]) + longint'($urandom_range(0, 2 * r)) - r);
          if (k == 0 && $urandom_range(0, 3) == 0)
            p[k] = Q_W'(longint'(p[k]) + ($urandom_range(0, 1) ? cur_box : -cur_box));
        end else begin
          p[k] = $urandom;
        end
      end
      send_particle(p[0], p[1], p[2], any_velocity(), any_velocity(), any_velocity(),
                    any_mass(), i == n - 1);
    end
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic settle();
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic configure(input logic [CFG_W-1:0] bx, by, bz, ts, sp);
    settle();
    write_reg(CFG_BOX_X, bx);
    write_reg(CFG_BOX_Y, by);
    write_reg(CFG_BOX_Z, bz);
    write_reg(CFG_TSTEP, ts);
    write_reg(CFG_SPACING, sp);
    cur_box     = bx;
    cur_spacing = sp;
  endtask

  initial begin
    int items;
    rst           = 1'b1;
    start         = 1'b0;
    pos_x         = '0;
    pos_y         = '0;
    pos_z         = '0;
    vel_in_x      = '0;
    vel_in_y      = '0;
    vel_in_z      = '0;
    density       = 31'd1;
    last_particle = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_BOX_X;
    cfg_data      = '0;
    burst_left    = 0;
    cur_box       = BOX_RST;
    cur_spacing   = SPACING_RST;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // Directed: a lone particle, extreme velocities and masses in contact,
    // contact across the wrap with no closing speed, and extreme positions.
    send_particle(Q_MAX, Q_MIN, 0, Q_MIN, Q_MAX, 0, 31'h7FFF_FFFF, 1'b1);
    send_particle(0, 0, 0, Q_MAX, Q_MIN, 0, 31'd1, 1'b0);
    send_particle(100, -100, 50, Q_MIN, Q_MAX, 65536, 31'h7FFF_FFFF, 1'b1);
    send_particle(-32760, 10, 0, 5000, 5000, 5000, 31'd65536, 1'b0);
    send_particle(32770, 10, 0, 5000, 5000, 5000, 31'd65536, 1'b1);
    send_particle(Q_MIN, Q_MIN, Q_MIN, 0, 0, 0, 31'd65536, 1'b0);
    send_particle(Q_MAX, Q_MAX, Q_MAX, 0, 0, 0, 31'd65536, 1'b1);
    send_set(3, 1'b1);

    // A vanishing denominator: impulse pinned positive, negative and zero.
    configure(BOX_RST, BOX_RST, BOX_RST, 31'd1, SPACING_RST);
    send_particle(0, 0, 0, 65536, 0, 0, 31'd1, 1'b0);
    send_particle(1000, 0, 0, -65536, 0, 0, 31'd1, 1'b1);
    send_particle(0, 0, 0, -65536, 0, 0, 31'd1, 1'b0);
    send_particle(1000, 0, 0, 65536, 0, 0, 31'd1, 1'b1);
    send_particle(0, 0, 0, 777, 0, 0, 31'd1, 1'b0);
    send_particle(1000, 0, 0, 777, 0, 0, 31'd1, 1'b1);

    items = 0;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: configure(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                     31'h7FFF_FFFF);
        1: configure(31'd0, 31'd0, 31'd0, 31'd1, 31'd65536);
        2: configure(31'd65536, 31'd65536, 31'd65536, 31'd0, 31'd0);
        3: configure($urandom, $urandom, $urandom, $urandom_range(1, 32'h7FFF_FFFF),
                     $urandom);
        default: configure($urandom_range(1 << 14, 1 << 20), $urandom_range(1 << 14, 1 << 20),
                           $urandom_range(1 << 14, 1 << 20), $urandom_range(1, 1 << 20),
                           $urandom_range(1 << 10, 1 << 17));
      endcase
      for (int c = 0; c < 20; ) begin
        int n;
        n = $urandom_range(1, 6);
        send_set(n, $urandom_range(0, 4) != 0);
        c += n;
        items += n;
      end
    end

    // Store full: a spread-out full set, then dropped extras, the last of
    // which still starts the pass.
    configure(BOX_RST, BOX_RST, BOX_RST, TSTEP_RST, SPACING_RST);
    for (int i = 0; i < MAX_PARTICLES_DEF; i++)
      send_particle($urandom, $urandom, $urandom, any_velocity(), any_velocity(),
                    any_velocity(), any_mass(), 1'b0);
    for (int i = 0; i < 3; i++)
      send_particle($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    any_mass(), i == 2);

    settle();
    repeat (200) @(negedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
